// ===== src/sgr_pkg.sv =====
package sgr_pkg;

   // Parameter string characters
   localparam logic [7:0] CHAR_EMPTY   = 8'h00;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_1       = 8'h31;
   localparam logic [7:0] CHAR_2       = 8'h32;
   localparam logic [7:0] CHAR_3       = 8'h33;
   localparam logic [7:0] CHAR_4       = 8'h34;
   localparam logic [7:0] CHAR_5       = 8'h35;
   localparam logic [7:0] CHAR_7       = 8'h37;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_BRACKET = 8'h5B;

   // Attribute constants
   localparam logic [7:0] ATTR_DEFAULT = 8'h07;
   localparam logic [7:0] FG_INTENSITY = 8'h08;
   localparam logic [7:0] FG_UNDERLINE = 8'h03;
   localparam logic [7:0] FG_KEEP_MASK = 8'hF8;
   localparam logic [7:0] BG_KEEP_MASK = 8'h8F;
   localparam logic [2:0] FG_DEFAULT   = 3'h7;
   localparam logic [2:0] BG_DEFAULT   = 3'h0;

   // Outcome of applying one parameter
   typedef struct packed {
      logic       ok;
      logic [7:0] attr;
      logic       reverse;
   } param_result_type;

   // ANSI color index to console BGR bits
   function automatic logic [2:0] ansi_to_bgr(input logic [2:0] idx);
      logic [2:0] bgr;
      unique case (idx)
         3'd0: bgr = 3'h0;
         3'd1: bgr = 3'h4;
         3'd2: bgr = 3'h2;
         3'd3: bgr = 3'h6;
         3'd4: bgr = 3'h1;
         3'd5: bgr = 3'h5;
         3'd6: bgr = 3'h3;
         default: bgr = 3'h7;
      endcase
      return bgr;
   endfunction

endpackage

// ===== src/sgr_param_decode.sv =====
module sgr_param_decode (
   input  logic [7:0]                first_digit,
   input  logic [7:0]                second_digit,
   input  logic [7:0]                attr,
   input  logic                      reverse,
   output sgr_pkg::param_result_type result
);
   import sgr_pkg::*;

   // Font codes: reset, bold, underline, reverse
   function automatic param_result_type font_code(input logic [7:0] c,
                                                  input logic [7:0] a,
                                                  input logic       rv);
      param_result_type r;
      r.ok      = 1'b1;
      r.attr    = a;
      r.reverse = rv;
      priority if (c == CHAR_EMPTY || c == CHAR_0) begin
         r.attr    = ATTR_DEFAULT;
         r.reverse = 1'b0;
      end else if (c == CHAR_1) begin
         r.attr = a | FG_INTENSITY;
      end else if (c == CHAR_2 || c == CHAR_3) begin
         r.attr = a;
      end else if (c == CHAR_4) begin
         r.attr = a | FG_UNDERLINE;
      end else if (c == CHAR_5 || c == CHAR_7) begin
         r.reverse = 1'b1;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // Clear codes
   function automatic param_result_type clear_code(input logic [7:0] c,
                                                   input logic [7:0] a,
                                                   input logic       rv);
      param_result_type r;
      r.ok      = 1'b1;
      r.attr    = a;
      r.reverse = rv;
      priority if (c == CHAR_2) begin
         r.attr = a & ~FG_INTENSITY;
      end else if (c == CHAR_4) begin
         r.attr = a & ~FG_UNDERLINE;
      end else if (c == CHAR_5 || c == CHAR_7) begin
         r.reverse = 1'b0;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   logic       color_valid;
   logic [2:0] fg_color;
   logic [2:0] bg_color;

   // Color digit decode; '9' selects the default
   always_comb begin
      color_valid = 1'b0;
      fg_color    = FG_DEFAULT;
      bg_color    = BG_DEFAULT;
      if (second_digit >= CHAR_0 && second_digit <= CHAR_7) begin
         color_valid = 1'b1;
         fg_color    = ansi_to_bgr(second_digit[2:0]);
         bg_color    = ansi_to_bgr(second_digit[2:0]);
      end else if (second_digit == CHAR_9) begin
         color_valid = 1'b1;
      end
   end

   // Parameter dispatch on the first character
   always_comb begin
      result.ok      = 1'b0;
      result.attr    = attr;
      result.reverse = reverse;
      priority if (first_digit == CHAR_0) begin
         result = font_code(second_digit, attr, reverse);
      end else if (second_digit == CHAR_EMPTY) begin
         result = font_code(first_digit, attr, reverse);
      end else if (first_digit == CHAR_1) begin
         result = font_code(second_digit, attr, reverse);
      end else if (first_digit == CHAR_2) begin
         result = clear_code(second_digit, attr, reverse);
      end else if (first_digit == CHAR_3) begin
         result.ok   = color_valid;
         result.attr = color_valid ? ((attr & FG_KEEP_MASK) | {5'b0, fg_color}) : attr;
      end else if (first_digit == CHAR_4) begin
         result.ok   = color_valid;
         result.attr = color_valid ? ((attr & BG_KEEP_MASK) | {1'b0, bg_color, 4'b0})
                                   : attr;
      end else begin
         result.ok = 1'b0;
      end
   end

endmodule

// ===== src/sgr_attribute_parser_core.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_char_code[7:0], req_last_byte
// rsp      out        rsp_valid/rsp_ready  rsp_attribute[7:0], rsp_accepted
//
// One byte is taken per cycle while no final byte stalls. A byte is held in the
// input register, then the parameter decode and attribute update run into the
// state and the result register, which holds the result of a final byte.
// Synchronous reset restores white on black.
// Only a final byte can stall, when the result register is still full;
// other bytes pass through the decode stage freely.
module sgr_attribute_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_attribute,
   output logic       rsp_accepted
);
   import sgr_pkg::*;

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;

   // Parser state
   logic [7:0] committed_ff, committed_in;
   logic [7:0] working_ff, working_in;
   logic       reverse_ff, reverse_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       abandoned_ff, abandoned_in;
   logic       in_seq_ff, in_seq_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_attribute_ff, rsp_attribute_in;
   logic       rsp_accepted_ff, rsp_accepted_in;

   logic       advance;
   logic [7:0] base_attr;
   logic [7:0] base_first;
   logic [7:0] base_second;
   logic       base_abandoned;
   logic [7:0] final_attr;
   param_result_type dec;

   // Handshake: a final byte waits for room in the result register
   assign advance   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Sequence start loads the working copy
   assign base_attr      = in_seq_ff ? working_ff : committed_ff;
   assign base_first     = in_seq_ff ? first_ff : CHAR_EMPTY;
   assign base_second    = in_seq_ff ? second_ff : CHAR_EMPTY;
   assign base_abandoned = in_seq_ff && abandoned_ff;

   sgr_param_decode u_decode (
      .first_digit  (base_first),
      .second_digit (base_second),
      .attr         (base_attr),
      .reverse      (reverse_ff),
      .result       (dec)
   );

   // Byte handling and attribute update
   always_comb begin
      working_in   = base_attr;
      reverse_in   = reverse_ff;
      first_in     = base_first;
      second_in    = base_second;
      abandoned_in = base_abandoned;
      in_seq_in    = 1'b1;
      committed_in = committed_ff;
      if (!base_abandoned && s1_char_ff != CHAR_BRACKET) begin
         if (s1_char_ff == CHAR_SEMI || s1_last_ff) begin
            if (dec.ok) begin
               working_in = dec.attr;
               reverse_in = dec.reverse;
               first_in   = CHAR_EMPTY;
               second_in  = CHAR_EMPTY;
            end else begin
               abandoned_in = 1'b1;
            end
         end else if (base_first == CHAR_EMPTY) begin
            first_in = s1_char_ff;
         end else if (base_second == CHAR_EMPTY) begin
            second_in = s1_char_ff;
         end
      end

      final_attr = reverse_in ? {working_in[3:0], working_in[7:4]} : working_in;
      rsp_attribute_in = abandoned_in ? committed_ff : final_attr;
      rsp_accepted_in  = !abandoned_in;

      if (s1_last_ff) begin
         if (!abandoned_in) begin
            committed_in = final_attr;
         end
         in_seq_in    = 1'b0;
         abandoned_in = 1'b0;
         first_in     = CHAR_EMPTY;
         second_in    = CHAR_EMPTY;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         committed_ff <= ATTR_DEFAULT;
         working_ff   <= ATTR_DEFAULT;
         reverse_ff   <= 1'b0;
         first_ff     <= CHAR_EMPTY;
         second_ff    <= CHAR_EMPTY;
         abandoned_ff <= 1'b0;
         in_seq_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            committed_ff <= committed_in;
            working_ff   <= working_in;
            reverse_ff   <= reverse_in;
            first_ff     <= first_in;
            second_ff    <= second_in;
            abandoned_ff <= abandoned_in;
            in_seq_ff    <= in_seq_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_code;
         s1_last_ff <= req_last_byte;
      end
      if (advance && s1_last_ff) begin
         rsp_attribute_ff <= rsp_attribute_in;
         rsp_accepted_ff  <= rsp_accepted_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_attribute = rsp_attribute_ff;
   assign rsp_accepted  = rsp_accepted_ff;

   // An accepted sequence commits exactly the attribute it reports
   a_commit_match: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff && rsp_accepted_in) |=> (committed_ff == rsp_attribute_ff))
      else $error("committed attribute differs from reported attribute");

   // An abandoned sequence reports the previous committed attribute
   a_abandon_repeat: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff && !rsp_accepted_in) |=>
         (rsp_attribute_ff == $past(committed_ff) && committed_ff == $past(committed_ff)))
      else $error("abandoned sequence changed the attribute");

   // The final byte closes the sequence
   a_seq_closed: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (!in_seq_ff && !abandoned_ff))
      else $error("sequence still open after final byte");

   // Abandon only exists inside an open sequence
   a_abandon_in_seq: assert property (@(posedge clock) disable iff (reset)
      abandoned_ff |-> in_seq_ff)
      else $error("abandon flag set outside a sequence");

endmodule
